>>> rtl/lewh_pkg.sv
`timescale 1ns / 1ps

package lewh_pkg;

    // Command codes
    localparam logic [3:0] CMD_INSERT    = 4'd0;
    localparam logic [3:0] CMD_ACCEPT    = 4'd1;
    localparam logic [3:0] CMD_BACKSPACE = 4'd2;
    localparam logic [3:0] CMD_DELETE    = 4'd3;
    localparam logic [3:0] CMD_RIGHT     = 4'd4;
    localparam logic [3:0] CMD_LEFT      = 4'd5;
    localparam logic [3:0] CMD_TRANSPOSE = 4'd6;
    localparam logic [3:0] CMD_HOME      = 4'd7;
    localparam logic [3:0] CMD_END       = 4'd8;
    localparam logic [3:0] CMD_WORDRIGHT = 4'd9;
    localparam logic [3:0] CMD_WORDLEFT  = 4'd10;
    localparam logic [3:0] CMD_KILL      = 4'd11;
    localparam logic [3:0] CMD_CLEAR     = 4'd12;
    localparam logic [3:0] CMD_PREVHIST  = 4'd13;
    localparam logic [3:0] CMD_NEXTHIST  = 4'd14;
    localparam logic [3:0] CMD_FINDHIST  = 4'd15;

    // Character codes
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TILDE      = 8'h7E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DIGIT_0    = 8'h30;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    typedef struct packed {
        logic [3:0] command;
        logic [7:0] key_char;
    } cmd_t;

    typedef struct packed {
        logic       status;
        logic [5:0] cursor;
        logic [5:0] line_length;
        logic [7:0] line_char;
        logic       char_valid;
        logic       last;
    } res_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_print(input logic [7:0] c);
        return (c >= CH_SPACE) && (c <= CH_TILDE);
    endfunction

endpackage

>>> rtl/lewh_ram.sv
`timescale 1ns / 1ps

module lewh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/line_editor_with_history_unit.sv
`timescale 1ns / 1ps

// Line editor with a ring of recent lines.
// Command channel: cmd_valid / cmd_stall carry one cmd_t beat (command, key_char).
// Result channel: res_valid / res_stall carry res_t beats. Each command gives one
// result beat with last set; accept gives one beat per character of the line
// (char_valid set, last on the final one), or a single beat for an empty line.
// The block works on one command at a time and holds cmd_stall high until the
// final result beat of that command sits in the output register.
// The single read port of the line store is walked one character at a time:
// cursor moves, kill and clear do not walk it; insert and delete walk each
// character moved; accept walks each character; history steps walk each
// character copied; search walks the kept lines, each line and the pattern.
// A stalled result beat holds in the output register and the sequencer waits.
// Reset clears cursor, length, ring pointers, line lengths and the output valid;
// the character stores need no clearing.
module line_editor_with_history_unit
    import lewh_pkg::*;
#(
    parameter int LINE_LEN   = 64,
    parameter int HIST_DEPTH = 16,
    parameter int TAB_WIDTH  = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd_data,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_data
);

    localparam int PW     = $clog2(LINE_LEN);
    localparam int SW     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int EW     = $clog2(LINE_LEN + TAB_WIDTH);
    localparam int HAW    = SW + PW;
    localparam int HDEPTH = HIST_DEPTH * (2 ** PW);
    localparam logic [PW-1:0] MAXLEN = PW'(LINE_LEN - 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(HIST_DEPTH - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_INS_RD, S_INS_WR, S_INS_FILL, S_SHL_RD, S_SHL_WR,
        S_TR_A, S_TR_B, S_TR_WA, S_TR_WB, S_WR_RD, S_WR_CHK, S_WL_RD, S_WL_CHK,
        S_ACC_RD, S_ACC_OUT, S_CP_RD, S_CP_WR, S_LOAD, S_FIND_START,
        S_FIND_NEXT, S_FIND_TRY, S_CMP_RD, S_CMP_CHK, S_RESP
    } state_t;

    typedef enum logic [1:0] {CP_SAVE, CP_LOAD, CP_RESTORE} cp_mode_t;

    state_t         state_reg;
    state_t         ret_reg;
    cp_mode_t       cp_mode_reg;
    logic [3:0]     op_reg;
    logic [7:0]     key_reg;
    logic [7:0]     tmp_reg;
    logic [EW-1:0]  shamt_reg;
    logic [EW-1:0]  cnt_reg;
    logic [PW-1:0]  j_reg;
    logic [PW-1:0]  q_reg;
    logic [PW-1:0]  n_reg;
    logic           phase_reg;
    logic           st_reg;
    logic [SW-1:0]  slot_reg;
    logic [SW-1:0]  fcnt_reg;

    logic [PW-1:0]  cur_reg;
    logic [PW-1:0]  len_reg;
    logic [PW-1:0]  saved_len_reg;
    logic [SW-1:0]  newest_reg;
    logic [SW-1:0]  oldest_reg;
    logic [SW-1:0]  browse_reg;
    logic [SW-1:0]  count_reg;
    logic [PW-1:0]  hlen_reg [HIST_DEPTH];

    logic           out_valid_reg;
    res_t           out_reg;

    logic           h_we;
    logic [HAW-1:0] h_waddr;
    logic [7:0]     h_wdata;
    logic [HAW-1:0] h_raddr;
    logic [7:0]     h_rdata;
    logic           s_we;
    logic [PW-1:0]  s_waddr;
    logic [7:0]     s_wdata;
    logic [PW-1:0]  s_raddr;
    logic [7:0]     s_rdata;

    logic           out_free;
    logic           out_load;
    logic [PW-1:0]  ins_dst;
    logic [PW-1:0]  slot_len;
    logic           tab_fits;
    logic [SW:0]    ring_span;

    function automatic logic [SW-1:0] ring_prev(input logic [SW-1:0] s);
        return (s == '0) ? LAST_SLOT : s - 1'b1;
    endfunction

    function automatic logic [SW-1:0] ring_next(input logic [SW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    lewh_ram #(
        .WIDTH (8),
        .DEPTH (HDEPTH),
        .AW    (HAW)
    ) u_hist_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    lewh_ram #(
        .WIDTH (8),
        .DEPTH (LINE_LEN),
        .AW    (PW)
    ) u_saved_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;
    assign out_free  = !out_valid_reg || !res_stall;
    assign out_load  = ((state_reg == S_RESP) || (state_reg == S_ACC_OUT)) && out_free;
    assign ins_dst   = PW'(EW'(j_reg) + shamt_reg - EW'(1));
    assign slot_len  = (slot_reg == newest_reg) ? len_reg : hlen_reg[slot_reg];
    assign tab_fits  = (EW'(len_reg) + EW'(TAB_WIDTH)) <= EW'(MAXLEN);
    assign ring_span = (newest_reg >= oldest_reg) ?
                       ((SW+1)'(newest_reg) - (SW+1)'(oldest_reg)) :
                       ((SW+1)'(newest_reg) + (SW+1)'(HIST_DEPTH) - (SW+1)'(oldest_reg));

    // Drive the store ports from the sequencer state
    always_comb
    begin
        h_we    = 1'b0;
        h_waddr = '0;
        h_wdata = '0;
        h_raddr = '0;
        s_we    = 1'b0;
        s_waddr = '0;
        s_wdata = '0;
        s_raddr = '0;
        unique case (state_reg)
            S_INS_RD:
            begin
                h_raddr = {newest_reg, j_reg - 1'b1};
            end
            S_INS_WR:
            begin
                h_we    = 1'b1;
                h_waddr = {newest_reg, ins_dst};
                h_wdata = h_rdata;
            end
            S_INS_FILL:
            begin
                h_we    = 1'b1;
                h_waddr = {newest_reg, PW'(EW'(cur_reg) + cnt_reg)};
                h_wdata = key_reg;
            end
            S_SHL_RD, S_TR_A, S_WR_RD, S_WL_RD, S_ACC_RD:
            begin
                h_raddr = {newest_reg, j_reg};
            end
            S_SHL_WR:
            begin
                h_we    = 1'b1;
                h_waddr = {newest_reg, j_reg - 1'b1};
                h_wdata = h_rdata;
            end
            S_TR_B:
            begin
                h_raddr = {newest_reg, j_reg + 1'b1};
            end
            S_TR_WA:
            begin
                h_we    = 1'b1;
                h_waddr = {newest_reg, j_reg};
                h_wdata = h_rdata;
            end
            S_TR_WB:
            begin
                h_we    = 1'b1;
                h_waddr = {newest_reg, j_reg + 1'b1};
                h_wdata = tmp_reg;
            end
            S_ACC_OUT:
            begin
                h_raddr = {newest_reg, j_reg};
                s_we    = out_free;
                s_waddr = j_reg;
                s_wdata = h_rdata;
            end
            S_CP_RD:
            begin
                s_raddr = j_reg;
                h_raddr = {(cp_mode_reg == CP_LOAD) ? browse_reg : newest_reg, j_reg};
            end
            S_CP_WR:
            begin
                if (cp_mode_reg == CP_SAVE)
                begin
                    s_we    = 1'b1;
                    s_waddr = j_reg;
                    s_wdata = h_rdata;
                end
                else
                begin
                    h_we    = 1'b1;
                    h_waddr = {newest_reg, j_reg};
                    h_wdata = (cp_mode_reg == CP_RESTORE) ? s_rdata : h_rdata;
                end
            end
            S_CMP_RD:
            begin
                h_raddr = {slot_reg, j_reg + q_reg};
                s_raddr = q_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer, line state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_RESP;
            cp_mode_reg   <= CP_SAVE;
            op_reg        <= CMD_INSERT;
            key_reg       <= '0;
            tmp_reg       <= '0;
            shamt_reg     <= '0;
            cnt_reg       <= '0;
            j_reg         <= '0;
            q_reg         <= '0;
            n_reg         <= '0;
            phase_reg     <= 1'b0;
            st_reg        <= 1'b0;
            slot_reg      <= '0;
            fcnt_reg      <= '0;
            cur_reg       <= '0;
            len_reg       <= '0;
            saved_len_reg <= '0;
            newest_reg    <= '0;
            oldest_reg    <= '0;
            browse_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                hlen_reg[k] <= '0;
            end
        end
        else
        begin
            // Drop the result beat once taken, unless a new one replaces it
            if (out_valid_reg && !res_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        op_reg <= cmd_data.command;
                        st_reg <= 1'b0;
                        state_reg <= S_RESP;
                        unique case (cmd_data.command)
                            CMD_INSERT:
                            begin
                                j_reg   <= len_reg;
                                cnt_reg <= '0;
                                if (cmd_data.key_char == CH_TAB)
                                begin
                                    if (tab_fits)
                                    begin
                                        shamt_reg <= EW'(TAB_WIDTH);
                                        key_reg   <= CH_SPACE;
                                        state_reg <= (len_reg > cur_reg) ? S_INS_RD : S_INS_FILL;
                                    end
                                    else
                                    begin
                                        st_reg <= 1'b1;
                                    end
                                end
                                else if (is_print(cmd_data.key_char) && (len_reg < MAXLEN))
                                begin
                                    shamt_reg <= EW'(1);
                                    key_reg   <= cmd_data.key_char;
                                    state_reg <= (len_reg > cur_reg) ? S_INS_RD : S_INS_FILL;
                                end
                                else
                                begin
                                    st_reg <= 1'b1;
                                end
                            end
                            CMD_ACCEPT:
                            begin
                                saved_len_reg <= len_reg;
                                n_reg <= len_reg;
                                j_reg <= '0;
                                if (len_reg == '0)
                                begin
                                    cur_reg <= '0;
                                end
                                else
                                begin
                                    state_reg <= S_ACC_RD;
                                end
                            end
                            CMD_BACKSPACE:
                            begin
                                j_reg <= cur_reg;
                                if (cur_reg != '0)
                                begin
                                    state_reg <= S_SHL_RD;
                                end
                                else
                                begin
                                    st_reg <= 1'b1;
                                end
                            end
                            CMD_DELETE:
                            begin
                                j_reg <= cur_reg + 1'b1;
                                if (cur_reg < len_reg)
                                begin
                                    state_reg <= S_SHL_RD;
                                end
                                else
                                begin
                                    st_reg <= 1'b1;
                                end
                            end
                            CMD_RIGHT:
                            begin
                                if (cur_reg < len_reg)
                                begin
                                    cur_reg <= cur_reg + 1'b1;
                                end
                                else
                                begin
                                    st_reg <= 1'b1;
                                end
                            end
                            CMD_LEFT:
                            begin
                                if (cur_reg != '0)
                                begin
                                    cur_reg <= cur_reg - 1'b1;
                                end
                                else
                                begin
                                    st_reg <= 1'b1;
                                end
                            end
                            CMD_TRANSPOSE:
                            begin
                                j_reg <= (cur_reg == len_reg) ? cur_reg - PW'(2) : cur_reg - 1'b1;
                                if ((cur_reg != '0) && (len_reg > PW'(1)))
                                begin
                                    state_reg <= S_TR_A;
                                end
                                else
                                begin
                                    st_reg <= 1'b1;
                                end
                            end
                            CMD_HOME:
                            begin
                                cur_reg <= '0;
                            end
                            CMD_END:
                            begin
                                cur_reg <= len_reg;
                            end
                            CMD_WORDRIGHT:
                            begin
                                j_reg     <= cur_reg + 1'b1;
                                phase_reg <= 1'b0;
                                if (cur_reg == len_reg)
                                begin
                                    st_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_WR_RD;
                                end
                            end
                            CMD_WORDLEFT:
                            begin
                                j_reg     <= cur_reg - 1'b1;
                                phase_reg <= 1'b0;
                                if (cur_reg == '0)
                                begin
                                    st_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_WL_RD;
                                end
                            end
                            CMD_KILL:
                            begin
                                len_reg <= cur_reg;
                            end
                            CMD_CLEAR:
                            begin
                                len_reg <= '0;
                                cur_reg <= '0;
                            end
                            CMD_PREVHIST:
                            begin
                                if (browse_reg == oldest_reg)
                                begin
                                    st_reg <= 1'b1;
                                end
                                else
                                begin
                                    browse_reg <= ring_prev(browse_reg);
                                    if (browse_reg == newest_reg)
                                    begin
                                        // Save the line being edited first
                                        saved_len_reg <= len_reg;
                                        cp_mode_reg   <= CP_SAVE;
                                        n_reg         <= len_reg;
                                        j_reg         <= '0;
                                        ret_reg       <= S_LOAD;
                                        state_reg     <= S_CP_RD;
                                    end
                                    else
                                    begin
                                        state_reg <= S_LOAD;
                                    end
                                end
                            end
                            CMD_NEXTHIST:
                            begin
                                if (browse_reg == newest_reg)
                                begin
                                    st_reg <= 1'b1;
                                end
                                else
                                begin
                                    browse_reg <= ring_next(browse_reg);
                                    if (ring_next(browse_reg) == newest_reg)
                                    begin
                                        // Restore the saved edit line
                                        len_reg     <= saved_len_reg;
                                        cur_reg     <= saved_len_reg;
                                        cp_mode_reg <= CP_RESTORE;
                                        n_reg       <= saved_len_reg;
                                        j_reg       <= '0;
                                        ret_reg     <= S_RESP;
                                        state_reg   <= S_CP_RD;
                                    end
                                    else
                                    begin
                                        state_reg <= S_LOAD;
                                    end
                                end
                            end
                            CMD_FINDHIST:
                            begin
                                st_reg <= 1'b1;
                                if (len_reg != '0)
                                begin
                                    browse_reg    <= newest_reg;
                                    saved_len_reg <= len_reg;
                                    cp_mode_reg   <= CP_SAVE;
                                    n_reg         <= len_reg;
                                    j_reg         <= '0;
                                    ret_reg       <= S_FIND_START;
                                    state_reg     <= S_CP_RD;
                                end
                                else
                                begin
                                    state_reg <= S_FIND_START;
                                end
                            end
                        endcase
                    end
                end

                // Insert: shift the tail right, then fill the gap
                S_INS_RD:
                begin
                    state_reg <= S_INS_WR;
                end
                S_INS_WR:
                begin
                    j_reg     <= j_reg - 1'b1;
                    state_reg <= ((j_reg - 1'b1) > cur_reg) ? S_INS_RD : S_INS_FILL;
                end
                S_INS_FILL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if ((cnt_reg + 1'b1) == shamt_reg)
                    begin
                        cur_reg   <= PW'(EW'(cur_reg) + shamt_reg);
                        len_reg   <= PW'(EW'(len_reg) + shamt_reg);
                        state_reg <= S_RESP;
                    end
                end

                // Backspace and delete: shift the tail left by one
                S_SHL_RD:
                begin
                    if (j_reg < len_reg)
                    begin
                        state_reg <= S_SHL_WR;
                    end
                    else
                    begin
                        if (op_reg == CMD_BACKSPACE)
                        begin
                            cur_reg <= cur_reg - 1'b1;
                        end
                        len_reg   <= len_reg - 1'b1;
                        state_reg <= S_RESP;
                    end
                end
                S_SHL_WR:
                begin
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= S_SHL_RD;
                end

                // Transpose: swap two neighbors
                S_TR_A:
                begin
                    state_reg <= S_TR_B;
                end
                S_TR_B:
                begin
                    tmp_reg   <= h_rdata;
                    state_reg <= S_TR_WA;
                end
                S_TR_WA:
                begin
                    state_reg <= S_TR_WB;
                end
                S_TR_WB:
                begin
                    if (cur_reg != len_reg)
                    begin
                        cur_reg <= cur_reg + 1'b1;
                    end
                    state_reg <= S_RESP;
                end

                // Word right: skip blanks, then word characters
                S_WR_RD:
                begin
                    if (j_reg < len_reg)
                    begin
                        state_reg <= S_WR_CHK;
                    end
                    else
                    begin
                        cur_reg   <= j_reg;
                        state_reg <= S_RESP;
                    end
                end
                S_WR_CHK:
                begin
                    if (!phase_reg && is_blank(h_rdata))
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_WR_RD;
                    end
                    else if (is_word(h_rdata))
                    begin
                        j_reg     <= j_reg + 1'b1;
                        phase_reg <= 1'b1;
                        state_reg <= S_WR_RD;
                    end
                    else
                    begin
                        cur_reg   <= j_reg;
                        state_reg <= S_RESP;
                    end
                end

                // Word left: same walk toward the start
                S_WL_RD:
                begin
                    if (j_reg != '0)
                    begin
                        state_reg <= S_WL_CHK;
                    end
                    else
                    begin
                        cur_reg   <= '0;
                        state_reg <= S_RESP;
                    end
                end
                S_WL_CHK:
                begin
                    if (!phase_reg && is_blank(h_rdata))
                    begin
                        j_reg     <= j_reg - 1'b1;
                        state_reg <= S_WL_RD;
                    end
                    else if (is_word(h_rdata))
                    begin
                        j_reg     <= j_reg - 1'b1;
                        phase_reg <= 1'b1;
                        state_reg <= S_WL_RD;
                    end
                    else
                    begin
                        cur_reg   <= j_reg;
                        state_reg <= S_RESP;
                    end
                end

                // Accept: stream characters, copy to the saved line, push
                S_ACC_RD:
                begin
                    state_reg <= S_ACC_OUT;
                end
                S_ACC_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg       <= 1'b1;
                        out_reg.status      <= 1'b0;
                        out_reg.cursor      <= '0;
                        out_reg.line_length <= '0;
                        out_reg.line_char   <= h_rdata;
                        out_reg.char_valid  <= 1'b1;
                        out_reg.last        <= (j_reg == (n_reg - 1'b1));
                        if (j_reg == (n_reg - 1'b1))
                        begin
                            hlen_reg[newest_reg] <= n_reg;
                            newest_reg <= ring_next(newest_reg);
                            browse_reg <= ring_next(newest_reg);
                            if (count_reg == LAST_SLOT)
                            begin
                                oldest_reg <= ring_next(oldest_reg);
                            end
                            else
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                            cur_reg   <= '0;
                            len_reg   <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_ACC_RD;
                        end
                    end
                end

                // Line copy between stores, or between slots of the history store
                S_CP_RD:
                begin
                    state_reg <= (j_reg < n_reg) ? S_CP_WR : ret_reg;
                end
                S_CP_WR:
                begin
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= S_CP_RD;
                end

                // Load the browsed slot into the edit slot
                S_LOAD:
                begin
                    if (browse_reg != newest_reg)
                    begin
                        len_reg     <= hlen_reg[browse_reg];
                        cur_reg     <= hlen_reg[browse_reg];
                        cp_mode_reg <= CP_LOAD;
                        n_reg       <= hlen_reg[browse_reg];
                        j_reg       <= '0;
                        ret_reg     <= S_RESP;
                        state_reg   <= S_CP_RD;
                    end
                    else
                    begin
                        cur_reg   <= len_reg;
                        state_reg <= S_RESP;
                    end
                end

                // Search older slots for the saved line
                S_FIND_START:
                begin
                    slot_reg  <= browse_reg;
                    fcnt_reg  <= '0;
                    state_reg <= S_FIND_NEXT;
                end
                S_FIND_NEXT:
                begin
                    if (fcnt_reg != count_reg)
                    begin
                        slot_reg  <= ring_prev(slot_reg);
                        fcnt_reg  <= fcnt_reg + 1'b1;
                        state_reg <= S_FIND_TRY;
                    end
                    else
                    begin
                        browse_reg <= newest_reg;
                        cur_reg    <= '0;
                        len_reg    <= '0;
                        state_reg  <= S_RESP;
                    end
                end
                S_FIND_TRY:
                begin
                    j_reg <= '0;
                    q_reg <= '0;
                    n_reg <= slot_len;
                    if (saved_len_reg == '0)
                    begin
                        browse_reg <= slot_reg;
                        st_reg     <= 1'b0;
                        state_reg  <= S_LOAD;
                    end
                    else if (saved_len_reg > slot_len)
                    begin
                        state_reg <= S_FIND_NEXT;
                    end
                    else
                    begin
                        state_reg <= S_CMP_RD;
                    end
                end
                S_CMP_RD:
                begin
                    state_reg <= S_CMP_CHK;
                end
                S_CMP_CHK:
                begin
                    if (h_rdata == s_rdata)
                    begin
                        if ((q_reg + 1'b1) == saved_len_reg)
                        begin
                            browse_reg <= slot_reg;
                            st_reg     <= 1'b0;
                            state_reg  <= S_LOAD;
                        end
                        else
                        begin
                            q_reg     <= q_reg + 1'b1;
                            state_reg <= S_CMP_RD;
                        end
                    end
                    else
                    begin
                        q_reg <= '0;
                        j_reg <= j_reg + 1'b1;
                        if ((EW'(j_reg) + EW'(1) + EW'(saved_len_reg)) > EW'(n_reg))
                        begin
                            state_reg <= S_FIND_NEXT;
                        end
                        else
                        begin
                            state_reg <= S_CMP_RD;
                        end
                    end
                end

                // Emit the single result beat
                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg       <= 1'b1;
                        out_reg.status      <= st_reg;
                        out_reg.cursor      <= 6'(cur_reg);
                        out_reg.line_length <= 6'(len_reg);
                        out_reg.line_char   <= '0;
                        out_reg.char_valid  <= 1'b0;
                        out_reg.last        <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // Cursor stays within the line between commands
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cur_reg <= len_reg))
        else $error("cursor beyond line length");

    // Line never grows past the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= MAXLEN)
        else $error("line length over limit");

    // Only accepted characters come without last
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.last) |-> res_data.char_valid)
        else $error("non-final beat without character");

    // Kept line count matches the ring pointers
    assert property (@(posedge clk) disable iff (!rst_n)
        (SW+1)'(count_reg) == ring_span)
        else $error("history count out of step with ring");

endmodule
